// File: rtl/afrf_pkg.sv
// Package for the alert frame receive filter: constants, verdict codes,
// register indexes, the CRC byte function and the job word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package afrf_pkg;

    localparam int FRAME_BYTES      = 18;
    localparam int CRC_BYTES        = 16;
    localparam int COUNT_MAX        = 31;
    localparam int DEDUP_SLOTS_DEF  = 16;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [31:0] WINDOW_RESET = 32'd60000;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_LENGTH   = 3'd1,
        VERDICT_MAGIC    = 3'd2,
        VERDICT_CRC      = 3'd3,
        VERDICT_VERSION  = 3'd4,
        VERDICT_RELAYED  = 3'd5,
        VERDICT_SELF     = 3'd6,
        VERDICT_DUP      = 3'd7
    } verdict_t;

    localparam logic [2:0] REG_MAGIC_FIRST  = 3'd0;
    localparam logic [2:0] REG_MAGIC_SECOND = 3'd1;
    localparam logic [2:0] REG_VERSION      = 3'd2;
    localparam logic [2:0] REG_OWN_ID       = 3'd3;
    localparam logic [2:0] REG_WINDOW       = 3'd4;

    // Decoded frame fields handed from front to back
    typedef struct packed {
        logic [2:0]  verdict;     // pre-dedup verdict
        logic [7:0]  frame_flags;
        logic [15:0] sender_id;
        logic [7:0]  sequence_no;
        logic [7:0]  hop_count;
        logic [7:0]  alert_tier;
        logic [7:0]  epoch_no;
        logic [15:0] score_hundredths;
        logic [15:0] threshold_milli;
        logic [31:0] time_ms;
    } job_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  frame_flags;
        logic [15:0] sender_id;
        logic [7:0]  sequence_no;
        logic [7:0]  hop_count;
        logic [7:0]  alert_tier;
        logic [7:0]  epoch_no;
        logic [15:0] score_hundredths;
        logic [15:0] threshold_milli;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } back_state_t;

    // CRC-16/CCITT-FALSE update for one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/afrf_front.sv
// Front end: collects frame bytes, runs the CRC, checks length, magic, crc,
// version, hop and self, and pushes one job word per frame. Uses afrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afrf_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 frame_end,
    input  wire logic [31:0]          time_ms,
    input  wire logic [7:0]           magic_first,
    input  wire logic [7:0]           magic_second,
    input  wire logic [7:0]           protocol_version,
    input  wire logic [15:0]          own_device_id,
    output logic                      job_valid,
    output afrf_pkg::job_t            job
);

    logic [7:0]  store_reg [afrf_pkg::FRAME_BYTES];
    logic [4:0]  count_reg;
    logic [15:0] crc_reg;
    logic [4:0]  count_next;
    logic [15:0] crc_upd;

    assign crc_upd = afrf_pkg::crc_byte(crc_reg, rx_byte);
    assign count_next = (count_reg < 5'(afrf_pkg::COUNT_MAX)) ? count_reg + 5'd1 : count_reg;

    // Byte store, written at the current count
    always_ff @(posedge clk)
    begin
        if (in_valid && count_reg < 5'(afrf_pkg::FRAME_BYTES))
            store_reg[count_reg] <= rx_byte;
    end

    // Count and CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= afrf_pkg::CRC_INIT;
        end
        else if (in_valid)
        begin
            if (frame_end)
            begin
                count_reg <= '0;
                crc_reg   <= afrf_pkg::CRC_INIT;
            end
            else
            begin
                count_reg <= count_next;
                if (count_reg < 5'(afrf_pkg::CRC_BYTES))
                    crc_reg <= crc_upd;
            end
        end
    end

    // Final byte is byte 17 when the length is right; use it directly
    logic [7:0]  f [afrf_pkg::FRAME_BYTES];
    logic [2:0]  verdict;
    logic [15:0] id;

    always_comb
    begin
        for (int i = 0; i < afrf_pkg::FRAME_BYTES; i++)
            f[i] = store_reg[i];
        f[afrf_pkg::FRAME_BYTES-1] = rx_byte;
        id = {f[5], f[4]};
        if (count_next != 5'(afrf_pkg::FRAME_BYTES))
            verdict = afrf_pkg::VERDICT_LENGTH;
        else if (f[0] != magic_first || f[1] != magic_second)
            verdict = afrf_pkg::VERDICT_MAGIC;
        else if (crc_reg != {f[17], f[16]})
            verdict = afrf_pkg::VERDICT_CRC;
        else if (f[2] != protocol_version)
            verdict = afrf_pkg::VERDICT_VERSION;
        else if (f[7] != 8'd0)
            verdict = afrf_pkg::VERDICT_RELAYED;
        else if (id == own_device_id)
            verdict = afrf_pkg::VERDICT_SELF;
        else
            verdict = afrf_pkg::VERDICT_OK;
    end

    // Job word
    assign job_valid = in_valid && frame_end;
    always_comb
    begin
        job.verdict          = verdict;
        job.frame_flags      = f[3];
        job.sender_id        = id;
        job.sequence_no      = f[6];
        job.hop_count        = f[7];
        job.alert_tier       = f[8];
        job.epoch_no         = f[9];
        job.score_hundredths = {f[11], f[10]};
        job.threshold_milli  = {f[13], f[12]};
        job.time_ms          = time_ms;
    end

endmodule
`default_nettype wire

// File: rtl/afrf_fifo.sv
// Small job queue between front end and dedup back end. Uses afrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afrf_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  afrf_pkg::job_t      wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output afrf_pkg::job_t      rd_data,
    output logic                empty
);

    afrf_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule
`default_nettype wire

// File: rtl/afrf_back.sv
// Back end: dedup table scan, one slot per cycle, then the result register.
// Uses afrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afrf_back
#(
    parameter int DEDUP_SLOTS = afrf_pkg::DEDUP_SLOTS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_avail,
    input  afrf_pkg::job_t      job,
    output logic                job_take,
    input  wire logic [31:0]    dedup_window_ms,
    output logic                res_valid,
    input  wire logic           res_take,
    output afrf_pkg::result_t   res
);

    localparam int SW = (DEDUP_SLOTS > 1) ? $clog2(DEDUP_SLOTS) : 1;
    localparam int CW = $clog2(DEDUP_SLOTS + 1);

    logic [DEDUP_SLOTS-1:0] used_reg, used_next;
    logic [15:0] snd_reg [DEDUP_SLOTS];
    logic [7:0]  seq_reg [DEDUP_SLOTS];
    logic [7:0]  ep_reg  [DEDUP_SLOTS];
    logic [31:0] tim_reg [DEDUP_SLOTS];

    afrf_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] rr_reg, rr_next;
    logic          free_reg, free_next;
    logic [SW-1:0] fslot_reg, fslot_next;
    logic          dup_reg, dup_next;
    afrf_pkg::result_t res_reg, res_next;
    logic          rv_reg, rv_next;
    logic          wr_en;
    logic [SW-1:0] wr_slot;
    logic [SW-1:0] cur;
    logic          expired, hit;

    assign cur     = idx_reg[SW-1:0];
    assign expired = (job.time_ms - tim_reg[cur]) >= dedup_window_ms;
    assign hit     = snd_reg[cur] == job.sender_id && seq_reg[cur] == job.sequence_no
                     && ep_reg[cur] == job.epoch_no;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    function automatic afrf_pkg::result_t mk(input afrf_pkg::job_t j, input logic [2:0] v);
        afrf_pkg::result_t r;
        r = '0;
        r.verdict = v;
        if (v == afrf_pkg::VERDICT_OK)
        begin
            r.frame_flags      = j.frame_flags;
            r.sender_id        = j.sender_id;
            r.sequence_no      = j.sequence_no;
            r.hop_count        = j.hop_count;
            r.alert_tier       = j.alert_tier;
            r.epoch_no         = j.epoch_no;
            r.score_hundredths = j.score_hundredths;
            r.threshold_milli  = j.threshold_milli;
        end
        return r;
    endfunction

    // Sequencer: pull a job, scan slots for a checked job, finish into the result register
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rr_next    = rr_reg;
        free_next  = free_reg;
        fslot_next = fslot_reg;
        dup_next   = dup_reg;
        used_next  = used_reg;
        res_next   = res_reg;
        rv_next    = rv_reg;
        job_take   = 1'b0;
        wr_en      = 1'b0;
        wr_slot    = fslot_reg;
        if (res_take)
            rv_next = 1'b0;
        unique case (state_reg)
            afrf_pkg::BK_IDLE:
            begin
                if (job_avail)
                begin
                    if (job.verdict != afrf_pkg::VERDICT_OK)
                    begin
                        if (!rv_reg || res_take)
                        begin
                            job_take = 1'b1;
                            res_next = mk(job, job.verdict);
                            rv_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        free_next  = 1'b0;
                        state_next = afrf_pkg::BK_SCAN;
                    end
                end
            end
            afrf_pkg::BK_SCAN:
            begin
                if (!used_reg[cur] || expired)
                begin
                    used_next[cur] = 1'b0;
                    if (!free_reg)
                    begin
                        free_next  = 1'b1;
                        fslot_next = cur;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else if (hit)
                begin
                    dup_next   = 1'b1;
                    state_next = afrf_pkg::BK_DONE;
                end
                else
                    idx_next = idx_reg + 1'b1;
                if (state_next == afrf_pkg::BK_SCAN
                    && idx_reg == CW'(DEDUP_SLOTS - 1))
                begin
                    wr_en   = 1'b1;
                    wr_slot = free_next ? fslot_next : rr_reg;
                    used_next[wr_slot] = 1'b1;
                    rr_next = (wr_slot == SW'(DEDUP_SLOTS - 1)) ? '0 : wr_slot + 1'b1;
                    dup_next   = 1'b0;
                    state_next = afrf_pkg::BK_DONE;
                end
            end
            afrf_pkg::BK_DONE:
            begin
                // Result register may still hold an older word; load only when free
                if (!rv_reg || res_take)
                begin
                    job_take   = 1'b1;
                    res_next   = mk(job, dup_reg ? afrf_pkg::VERDICT_DUP
                                                 : afrf_pkg::VERDICT_OK);
                    rv_next    = 1'b1;
                    state_next = afrf_pkg::BK_IDLE;
                end
            end
            default: state_next = afrf_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afrf_pkg::BK_IDLE;
            idx_reg   <= '0;
            rr_reg    <= '0;
            free_reg  <= 1'b0;
            fslot_reg <= '0;
            dup_reg   <= 1'b0;
            used_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rr_reg    <= rr_next;
            free_reg  <= free_next;
            fslot_reg <= fslot_next;
            dup_reg   <= dup_next;
            used_reg  <= used_next;
            rv_reg    <= rv_next;
        end
    end

    // Result payload and table contents
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (wr_en)
        begin
            snd_reg[wr_slot] <= job.sender_id;
            seq_reg[wr_slot] <= job.sequence_no;
            ep_reg[wr_slot]  <= job.epoch_no;
            tim_reg[wr_slot] <= job.time_ms;
        end
    end

endmodule
`default_nettype wire

// File: rtl/alert_frame_receive_filter_core.sv
// Alert frame receive filter: byte-wise frame check with dedup table.
// Path: a rejected frame's verdict passes through the job queue and the result register;
// a checked one also waits for the dedup scan, one slot a cycle.
// Throughput: one byte per cycle while full is low; full holds bytes off while the job queue is full.
// Reset: rst_n async active low clears counters, CRC, table used bits and queues.
`timescale 1ns / 1ps
`default_nettype none
module alert_frame_receive_filter_core
#(
    parameter int DEDUP_SLOTS = afrf_pkg::DEDUP_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_end,
    input  wire logic [31:0] time_ms,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       verdict,
    output logic [7:0]       frame_flags,
    output logic [15:0]      sender_id,
    output logic [7:0]       sequence_no,
    output logic [7:0]       hop_count,
    output logic [7:0]       alert_tier,
    output logic [7:0]       epoch_no,
    output logic [15:0]      score_hundredths,
    output logic [15:0]      threshold_milli,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [7:0]  magic_first_reg, magic_second_reg, version_reg;
    logic [15:0] own_id_reg;
    logic [31:0] window_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg  <= '0;
            magic_second_reg <= '0;
            version_reg      <= '0;
            own_id_reg       <= '0;
            window_reg       <= afrf_pkg::WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                afrf_pkg::REG_MAGIC_FIRST:  magic_first_reg  <= cfg_data[7:0];
                afrf_pkg::REG_MAGIC_SECOND: magic_second_reg <= cfg_data[7:0];
                afrf_pkg::REG_VERSION:      version_reg      <= cfg_data[7:0];
                afrf_pkg::REG_OWN_ID:       own_id_reg       <= cfg_data[15:0];
                afrf_pkg::REG_WINDOW:       window_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    logic in_valid, job_valid, q_full, q_empty, job_take, res_valid;
    afrf_pkg::job_t job_in, job_out;
    afrf_pkg::result_t res;

    assign in_valid = push && !full;
    // Hold off bytes while the job queue is full so no verdict is dropped
    assign full = q_full;

    afrf_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .rx_byte(rx_byte),
        .frame_end(frame_end), .time_ms(time_ms),
        .magic_first(magic_first_reg), .magic_second(magic_second_reg),
        .protocol_version(version_reg), .own_device_id(own_id_reg),
        .job_valid(job_valid), .job(job_in)
    );

    afrf_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .wr_en(job_valid), .wr_data(job_in), .full(q_full),
        .rd_en(job_take), .rd_data(job_out), .empty(q_empty)
    );

    afrf_back #(.DEDUP_SLOTS(DEDUP_SLOTS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .job_avail(!q_empty), .job(job_out),
        .job_take(job_take), .dedup_window_ms(window_reg),
        .res_valid(res_valid), .res_take(pop && res_valid), .res(res)
    );

    // Result ports
    assign empty            = !res_valid;
    assign verdict          = res.verdict;
    assign frame_flags      = res.frame_flags;
    assign sender_id        = res.sender_id;
    assign sequence_no      = res.sequence_no;
    assign hop_count        = res.hop_count;
    assign alert_tier       = res.alert_tier;
    assign epoch_no         = res.epoch_no;
    assign score_hundredths = res.score_hundredths;
    assign threshold_milli  = res.threshold_milli;

endmodule
`default_nettype wire
